// ----- rtl/amsu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package amsu_pkg;

  localparam int SITES_DEF = 64;
  localparam int SITE_W    = 6;
  localparam int RND_W     = 32;
  localparam int DE_W      = 4;
  localparam int MAG_OUT_W = 8;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_TWO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_SIX  = 2'd2;

  localparam logic [RND_W-1:0] THR_TWO_RST  = 32'd8;
  localparam logic [RND_W-1:0] THR_FOUR_RST = 32'd0;
  localparam logic [RND_W-1:0] THR_SIX_RST  = 32'd0;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_TRIAL = 1'b1;

  // energy change codes (two's complement, DE_W bits)
  localparam logic [DE_W-1:0] DE_ZERO      = 4'd0;
  localparam logic [DE_W-1:0] DE_RISE_TWO  = 4'd2;
  localparam logic [DE_W-1:0] DE_RISE_FOUR = 4'd4;

  localparam logic [RND_W-1:0] RND_HALF = 32'h8000_0000;

  typedef struct packed {
    logic [RND_W-1:0] two;
    logic [RND_W-1:0] four;
    logic [RND_W-1:0] six;
  } thr_t;

  typedef struct packed {
    logic in_range;
    logic own;
    logic l1;
    logic r1;
    logic l2;
    logic r2;
  } nbr_t;

  typedef struct packed {
    logic              en;
    logic [SITE_W-1:0] site;
  } upd_t;

  typedef struct packed {
    logic            flip;
    logic            spin_new;
    logic [DE_W-1:0] de;
  } dec_t;

endpackage

`default_nettype wire

// ----- rtl/amsu_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module amsu_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [amsu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [amsu_pkg::RND_W-1:0]     cfg_data,
  output amsu_pkg::thr_t                      thr
);

  amsu_pkg::thr_t thr_r, thr_nxt;

  assign cfg_ready = 1'b1;
  assign thr       = thr_r;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        amsu_pkg::CFG_THR_TWO:  thr_nxt.two  = cfg_data;
        amsu_pkg::CFG_THR_FOUR: thr_nxt.four = cfg_data;
        amsu_pkg::CFG_THR_SIX:  thr_nxt.six  = cfg_data;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.two  <= amsu_pkg::THR_TWO_RST;
      thr_r.four <= amsu_pkg::THR_FOUR_RST;
      thr_r.six  <= amsu_pkg::THR_SIX_RST;
    end else begin
      thr_r <= thr_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/amsu_spin_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none

module amsu_spin_ring #(
  parameter int SITES = amsu_pkg::SITES_DEF,
  parameter int MAG_W = $clog2(amsu_pkg::SITES_DEF + 1) + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [amsu_pkg::SITE_W-1:0] site,
  input  amsu_pkg::upd_t                   upd,
  output amsu_pkg::nbr_t                   nbr,
  output logic signed [MAG_W-1:0]          mag_nxt
);

  // Only the addressable sites are stored; the rest of a larger ring stays +1.
  localparam int STORE = (SITES < (1 << amsu_pkg::SITE_W)) ? SITES : (1 << amsu_pkg::SITE_W);
  localparam int AW    = $clog2(STORE);
  localparam int IDX_W = $clog2(SITES);
  localparam int NW    = ((IDX_W > amsu_pkg::SITE_W) ? IDX_W : amsu_pkg::SITE_W) + 1;

  logic [STORE-1:0]        spin_r, spin_nxt;
  logic signed [MAG_W-1:0] mag_r;
  logic [NW-1:0]           site_ext, sites_c, idx_l1, idx_r1, idx_l2, idx_r2;
  logic                    own_upd;

  function automatic logic rd_spin(input logic [STORE-1:0] v, input logic [NW-1:0] idx);
    return (idx < NW'(STORE)) ? v[idx[AW-1:0]] : 1'b0;
  endfunction

  always_comb begin
    site_ext = NW'(site);
    sites_c  = NW'(SITES);
    idx_r1   = site_ext + NW'(1);
    if (idx_r1 >= sites_c) idx_r1 = idx_r1 - sites_c;
    idx_r2   = site_ext + NW'(2);
    if (idx_r2 >= sites_c) idx_r2 = idx_r2 - sites_c;
    idx_l1   = (site_ext == '0) ? sites_c - NW'(1) : site_ext - NW'(1);
    idx_l2   = (site_ext < NW'(2)) ? site_ext + sites_c - NW'(2) : site_ext - NW'(2);
  end

  always_comb begin
    nbr.in_range = site_ext < sites_c;
    nbr.own      = rd_spin(spin_r, site_ext);
    nbr.l1       = rd_spin(spin_r, idx_l1);
    nbr.r1       = rd_spin(spin_r, idx_r1);
    nbr.l2       = rd_spin(spin_r, idx_l2);
    nbr.r2       = rd_spin(spin_r, idx_r2);
  end

  always_comb begin
    own_upd  = rd_spin(spin_r, NW'(upd.site));
    spin_nxt = spin_r;
    mag_nxt  = mag_r;
    if (upd.en) begin
      spin_nxt[upd.site[AW-1:0]] = ~own_upd;
      // -1 -> +1 raises the sum by 2, +1 -> -1 lowers it by 2
      mag_nxt = own_upd ? mag_r + MAG_W'(2) : mag_r - MAG_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_r <= '0;
      mag_r  <= MAG_W'(SITES);
    end else begin
      spin_r <= spin_nxt;
      mag_r  <= mag_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/amsu_flip_decide.sv -----
`timescale 1ns / 1ps
`default_nettype none

module amsu_flip_decide (
  input  wire logic                       action,
  input  wire logic                       load_spin,
  input  wire logic [amsu_pkg::RND_W-1:0] rnd,
  input  amsu_pkg::nbr_t                  nbr,
  input  amsu_pkg::thr_t                  thr,
  output amsu_pkg::dec_t                  dec
);

  logic [1:0]                agree1, agree2;
  logic [amsu_pkg::DE_W-1:0] de_calc;

  // dE = 4*(nearest agreeing) - 2*(next-nearest agreeing) - 2
  always_comb begin
    agree1  = {1'b0, nbr.l1 == nbr.own} + {1'b0, nbr.r1 == nbr.own};
    agree2  = {1'b0, nbr.l2 == nbr.own} + {1'b0, nbr.r2 == nbr.own};
    de_calc = {agree1, 2'b00} - {1'b0, agree2, 1'b0} - 4'd2;
  end

  always_comb begin
    dec = '0;
    if (nbr.in_range) begin
      if (action == amsu_pkg::ACT_LOAD) begin
        dec.flip = load_spin != nbr.own;
      end else begin
        dec.de = de_calc;
        if (de_calc[amsu_pkg::DE_W-1]) begin
          dec.flip = 1'b1;
        end else begin
          case (de_calc)
            amsu_pkg::DE_ZERO:      dec.flip = rnd <= amsu_pkg::RND_HALF;
            amsu_pkg::DE_RISE_TWO:  dec.flip = rnd < thr.two;
            amsu_pkg::DE_RISE_FOUR: dec.flip = rnd < thr.four;
            default:                dec.flip = rnd < thr.six;
          endcase
        end
      end
      dec.spin_new = nbr.own ^ dec.flip;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/annni_metropolis_spin_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A transaction accepted into the input register moves to the result register once the
// output is empty or not stalled, and its result is then on the ports.
// Throughput: one transaction per cycle while out_stall is low; spin reads, dE and the
// threshold compare sit between the input register and the result register, and the
// state updates with the result. Reset (synchronous, rst_n low): all spins +1,
// magnetization = SITES, thresholds 8/0/0, both pipeline registers empty.
module annni_metropolis_spin_update #(
  parameter int SITES = amsu_pkg::SITES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_action,
  input  wire logic [amsu_pkg::SITE_W-1:0]    in_site,
  input  wire logic                           in_load_spin,
  input  wire logic [amsu_pkg::RND_W-1:0]     in_random_frac,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [amsu_pkg::SITE_W-1:0]         out_site_out,
  output logic                                out_spin_out,
  output logic                                out_flipped,
  output logic signed [amsu_pkg::DE_W-1:0]    out_delta_energy,
  output logic signed [amsu_pkg::MAG_OUT_W-1:0] out_magnetization,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [amsu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [amsu_pkg::RND_W-1:0]     cfg_data
);

  localparam int MAG_W = $clog2(SITES + 1) + 1;

  logic                          in_valid_r, in_action_r, in_load_r;
  logic [amsu_pkg::SITE_W-1:0]   in_site_r;
  logic [amsu_pkg::RND_W-1:0]    in_rnd_r;
  logic                          out_valid_r, out_spin_r, out_flip_r;
  logic [amsu_pkg::SITE_W-1:0]   out_site_r;
  logic [amsu_pkg::DE_W-1:0]     out_de_r;
  logic [amsu_pkg::MAG_OUT_W-1:0] out_mag_r;
  logic                          out_free, move, in_take;
  logic signed [MAG_W-1:0]       mag_nxt;
  amsu_pkg::thr_t                thr;
  amsu_pkg::nbr_t                nbr;
  amsu_pkg::dec_t                dec;
  amsu_pkg::upd_t                upd;

  assign out_free = !out_valid_r || !out_stall;
  assign move     = in_valid_r && out_free;
  assign in_take  = !in_valid_r || move;
  assign in_stall = !in_take;

  assign upd = {move && dec.flip, in_site_r};

  amsu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  amsu_spin_ring #(
    .SITES (SITES),
    .MAG_W (MAG_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .site    (in_site_r),
    .upd     (upd),
    .nbr     (nbr),
    .mag_nxt (mag_nxt)
  );

  amsu_flip_decide u_decide (
    .action    (in_action_r),
    .load_spin (in_load_r),
    .rnd       (in_rnd_r),
    .nbr       (nbr),
    .thr       (thr),
    .dec       (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) in_valid_r <= in_valid;
      if (out_free) out_valid_r <= in_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take && in_valid) begin
      in_action_r <= in_action;
      in_site_r   <= in_site;
      in_load_r   <= in_load_spin;
      in_rnd_r    <= in_random_frac;
    end
    if (move) begin
      out_site_r <= in_site_r;
      out_spin_r <= dec.spin_new;
      out_flip_r <= dec.flip;
      out_de_r   <= dec.de;
      out_mag_r  <= amsu_pkg::MAG_OUT_W'(mag_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_site_out      = out_site_r;
  assign out_spin_out      = out_spin_r;
  assign out_flipped       = out_flip_r;
  assign out_delta_energy  = $signed(out_de_r);
  assign out_magnetization = $signed(out_mag_r);

endmodule

`default_nettype wire

// ----- rtl/amsu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module amsu_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [amsu_pkg::SITE_W-1:0]      out_site_out,
  input wire logic                             out_flipped,
  input wire logic [amsu_pkg::DE_W-1:0]        out_delta_energy,
  input wire logic [amsu_pkg::MAG_OUT_W-1:0]   out_magnetization
);

  // after an accepted transaction has passed the input register, out_valid must be high
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted transaction did not reach the output");

  // energy change is always even
  a_de_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_delta_energy[0])
    else $error("odd energy change");

  // an energy drop always flips
  a_drop_flips: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_delta_energy[amsu_pkg::DE_W-1] |-> out_flipped)
    else $error("energy drop without a flip");

  // without a flip the magnetization carries over from the previous result
  a_mag_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) ##1 (out_valid && !out_flipped)
      |-> out_magnetization == $past(out_magnetization))
    else $error("magnetization changed without a flip");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_site_out))
    else $error("stalled result changed");

endmodule

bind annni_metropolis_spin_update amsu_checker u_amsu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_site_out      (out_site_out),
  .out_flipped       (out_flipped),
  .out_delta_energy  (out_delta_energy),
  .out_magnetization (out_magnetization)
);

`default_nettype wire
